// ===== hdl/tbi_pkg.sv =====
package tbi_pkg;

	// Number of register stages in the geometry front end, from the accepted
	// transaction to the entry written into the queue.
	localparam int FRONT_LAT = 7;

	// Depth of the queue between the front end and the divider back end.
	localparam int QDEPTH = 16;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// The front end may have this many transactions in flight that have not
	// reached the queue yet, so the queue must keep that much room free.
	localparam int QROOM = FRONT_LAT + 1;

	typedef logic [QCNT_W-1:0] qcnt_t;

endpackage

// ===== hdl/tbi_front.sv =====
module tbi_front #(
	parameter int CB = 16,
	parameter int VB = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic signed [CB-1:0]               qx,
	input  logic signed [CB-1:0]               qy,
	input  logic signed [CB-1:0]               x1,
	input  logic signed [CB-1:0]               y1,
	input  logic signed [VB-1:0]               z1,
	input  logic signed [CB-1:0]               x2,
	input  logic signed [CB-1:0]               y2,
	input  logic signed [VB-1:0]               z2,
	input  logic signed [CB-1:0]               x3,
	input  logic signed [CB-1:0]               y3,
	input  logic signed [VB-1:0]               z3,
	output logic                               out_valid,
	output logic signed [2*CB+3+VB+2-1:0]      num,
	output logic signed [2*CB+3-1:0]           area
);

	localparam int AW = 2 * CB + 3;
	localparam int NW = AW + VB + 2;
	localparam int PW = 2 * CB;
	localparam int DW = CB + 1;
	localparam int EW = 2 * CB + 1;
	localparam int LW = (AW + 1) / 2;
	localparam int HW = AW - LW;

	logic [tbi_pkg::FRONT_LAT-1:0] v_q;

	// Stage 1: captured transaction.
	logic signed [CB-1:0] qx_s1, qy_s1, x1_s1, y1_s1, x2_s1, y2_s1, x3_s1, y3_s1;
	logic signed [VB-1:0] z1_s1, z2_s1, z3_s1;

	// Stage 2: cross products and edge vectors.
	logic signed [AW-1:0] c12_s2, c23_s2, c31_s2;
	logic signed [DW-1:0] dx1_s2, dy1_s2, dx2_s2, dy2_s2, dx3_s2, dy3_s2;
	logic signed [CB-1:0] qx_s2, qy_s2;
	logic signed [VB-1:0] z1_s2, z2_s2, z3_s2;

	// Stage 3: edge function products and twice the area.
	logic signed [EW-1:0] pa1_s3, pb1_s3, pa2_s3, pb2_s3, pa3_s3, pb3_s3;
	logic signed [AW-1:0] c12_s3, c23_s3, c31_s3, area_s3;
	logic signed [VB-1:0] z1_s3, z2_s3, z3_s3;

	// Stage 4: weight numerators.
	logic signed [AW-1:0] w1_s4, w2_s4, w3_s4, area_s4;
	logic signed [VB-1:0] z1_s4, z2_s4, z3_s4;

	// Stage 5: weight times value, split into low and high partial products.
	logic signed [LW+VB:0]   lo1_s5, lo2_s5, lo3_s5;
	logic signed [HW+VB-1:0] hi1_s5, hi2_s5, hi3_s5;
	logic signed [AW-1:0]    area_s5;

	// Stage 6: recombined products.
	logic signed [NW-1:0] wz1_s6, wz2_s6, wz3_s6;
	logic signed [AW-1:0] area_s6;

	// Stage 7: numerator.
	logic signed [NW-1:0] num_s7;
	logic signed [AW-1:0] area_s7;

	logic signed [PW-1:0] m12a, m12b, m23a, m23b, m31a, m31b;

	assign m12a = x1_s1 * y2_s1;
	assign m12b = y1_s1 * x2_s1;
	assign m23a = x2_s1 * y3_s1;
	assign m23b = y2_s1 * x3_s1;
	assign m31a = x3_s1 * y1_s1;
	assign m31b = y3_s1 * x1_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[tbi_pkg::FRONT_LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		qx_s1 <= qx;
		qy_s1 <= qy;
		x1_s1 <= x1;
		y1_s1 <= y1;
		z1_s1 <= z1;
		x2_s1 <= x2;
		y2_s1 <= y2;
		z2_s1 <= z2;
		x3_s1 <= x3;
		y3_s1 <= y3;
		z3_s1 <= z3;

		c12_s2 <= AW'(m12a) - AW'(m12b);
		c23_s2 <= AW'(m23a) - AW'(m23b);
		c31_s2 <= AW'(m31a) - AW'(m31b);
		dx1_s2 <= DW'(x3_s1) - DW'(x2_s1);
		dy1_s2 <= DW'(y3_s1) - DW'(y2_s1);
		dx2_s2 <= DW'(x1_s1) - DW'(x3_s1);
		dy2_s2 <= DW'(y1_s1) - DW'(y3_s1);
		dx3_s2 <= DW'(x2_s1) - DW'(x1_s1);
		dy3_s2 <= DW'(y2_s1) - DW'(y1_s1);
		qx_s2  <= qx_s1;
		qy_s2  <= qy_s1;
		z1_s2  <= z1_s1;
		z2_s2  <= z2_s1;
		z3_s2  <= z3_s1;

		pa1_s3  <= dx1_s2 * qy_s2;
		pb1_s3  <= dy1_s2 * qx_s2;
		pa2_s3  <= dx2_s2 * qy_s2;
		pb2_s3  <= dy2_s2 * qx_s2;
		pa3_s3  <= dx3_s2 * qy_s2;
		pb3_s3  <= dy3_s2 * qx_s2;
		c12_s3  <= c12_s2;
		c23_s3  <= c23_s2;
		c31_s3  <= c31_s2;
		area_s3 <= c12_s2 + c23_s2 + c31_s2;
		z1_s3   <= z1_s2;
		z2_s3   <= z2_s2;
		z3_s3   <= z3_s2;

		w1_s4   <= AW'(pa1_s3) - AW'(pb1_s3) + c23_s3;
		w2_s4   <= AW'(pa2_s3) - AW'(pb2_s3) + c31_s3;
		w3_s4   <= AW'(pa3_s3) - AW'(pb3_s3) + c12_s3;
		area_s4 <= area_s3;
		z1_s4   <= z1_s3;
		z2_s4   <= z2_s3;
		z3_s4   <= z3_s3;

		lo1_s5  <= $signed({1'b0, w1_s4[LW-1:0]}) * z1_s4;
		lo2_s5  <= $signed({1'b0, w2_s4[LW-1:0]}) * z2_s4;
		lo3_s5  <= $signed({1'b0, w3_s4[LW-1:0]}) * z3_s4;
		hi1_s5  <= $signed(w1_s4[AW-1:LW]) * z1_s4;
		hi2_s5  <= $signed(w2_s4[AW-1:LW]) * z2_s4;
		hi3_s5  <= $signed(w3_s4[AW-1:LW]) * z3_s4;
		area_s5 <= area_s4;

		wz1_s6  <= (NW'(hi1_s5) <<< LW) + NW'(lo1_s5);
		wz2_s6  <= (NW'(hi2_s5) <<< LW) + NW'(lo2_s5);
		wz3_s6  <= (NW'(hi3_s5) <<< LW) + NW'(lo3_s5);
		area_s6 <= area_s5;

		num_s7  <= wz1_s6 + wz2_s6 + wz3_s6;
		area_s7 <= area_s6;
	end

	assign out_valid = v_q[tbi_pkg::FRONT_LAT-1];
	assign num       = num_s7;
	assign area      = area_s7;

endmodule

// ===== hdl/tbi_queue.sv =====
module tbi_queue #(
	parameter int W = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [W-1:0]       wdata,
	output logic               out_valid,
	output logic [W-1:0]       rdata,
	output tbi_pkg::qcnt_t     count
);

	logic [W-1:0]               mem_q [tbi_pkg::QDEPTH];
	logic [tbi_pkg::QPTR_W-1:0] wptr_q, rptr_q;
	tbi_pkg::qcnt_t             cnt_q;
	logic                       pop;
	logic                       valid_q;
	logic [W-1:0]               rdata_q;

	// The back end never stalls, so an entry leaves as soon as it is there.
	assign pop = (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			cnt_q   <= cnt_q + tbi_pkg::qcnt_t'(push) - tbi_pkg::qcnt_t'(pop);
			valid_q <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
		rdata_q <= mem_q[rptr_q];
	end

	assign out_valid = valid_q;
	assign rdata     = rdata_q;
	assign count     = cnt_q;

endmodule

// ===== hdl/tbi_div.sv =====
module tbi_div #(
	parameter int CB = 16,
	parameter int VB = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic signed [2*CB+3+VB+2-1:0]  num,
	input  logic signed [2*CB+3-1:0]       area,
	output logic                           out_valid,
	output logic signed [VB-1:0]           res,
	output logic                           deg,
	output logic                           sat
);

	localparam int AW = 2 * CB + 3;
	localparam int NW = AW + VB + 2;
	localparam logic [VB-1:0] POSMAX = {1'b0, {(VB-1){1'b1}}};
	localparam logic [VB-1:0] NEGMAG = {1'b1, {(VB-1){1'b0}}};

	// Sign stage: magnitudes and the sign of the quotient.
	logic          v_s1, qn_s1, dg_s1;
	logic [NW-1:0] mag_s1;
	logic [AW-1:0] dv_s1;

	// Per-bit stages; index 0 is the overflow check.
	logic          v_q   [VB+1];
	logic          qn_q  [VB+1];
	logic          dg_q  [VB+1];
	logic          ov_q  [VB+1];
	logic [NW-1:0] rem_q [VB+1];
	logic [VB-1:0] quo_q [VB+1];
	logic [AW-1:0] dv_q  [VB+1];

	logic          v_o;
	logic [VB-1:0] res_o;
	logic          dg_o, sat_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_q[0] <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_q[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		mag_s1 <= num[NW-1] ? NW'(-num) : NW'(num);
		dv_s1  <= area[AW-1] ? AW'(-area) : AW'(area);
		qn_s1  <= num[NW-1] ^ area[AW-1];
		dg_s1  <= (area == '0);

		// A quotient of 2^VB or more saturates whatever its sign.
		ov_q[0]  <= (mag_s1 >= (NW'(dv_s1) << VB));
		rem_q[0] <= mag_s1;
		quo_q[0] <= '0;
		dv_q[0]  <= dv_s1;
		qn_q[0]  <= qn_s1;
		dg_q[0]  <= dg_s1;
	end

	for (genvar k = 0; k < VB; k++) begin : g_bit
		localparam int B = VB - 1 - k;
		logic [NW-1:0] sub;
		logic          take;

		assign sub  = NW'(dv_q[k]) << B;
		assign take = (rem_q[k] >= sub);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k+1] <= 1'b0;
			end else begin
				v_q[k+1] <= v_q[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_q[k+1] <= take ? rem_q[k] - sub : rem_q[k];
			quo_q[k+1] <= take ? (quo_q[k] | (VB'(1) << B)) : quo_q[k];
			dv_q[k+1]  <= dv_q[k];
			qn_q[k+1]  <= qn_q[k];
			dg_q[k+1]  <= dg_q[k];
			ov_q[k+1]  <= ov_q[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o <= 1'b0;
		end else begin
			v_o <= v_q[VB];
		end
	end

	always_ff @(posedge clk) begin
		dg_o <= dg_q[VB];
		if (dg_q[VB]) begin
			res_o <= '0;
			sat_o <= 1'b0;
		end else if (qn_q[VB]) begin
			if (ov_q[VB] || quo_q[VB] > NEGMAG) begin
				res_o <= NEGMAG;
				sat_o <= 1'b1;
			end else begin
				res_o <= VB'(-quo_q[VB]);
				sat_o <= 1'b0;
			end
		end else begin
			if (ov_q[VB] || quo_q[VB] > POSMAX) begin
				res_o <= POSMAX;
				sat_o <= 1'b1;
			end else begin
				res_o <= quo_q[VB];
				sat_o <= 1'b0;
			end
		end
	end

	assign out_valid = v_o;
	assign res       = $signed(res_o);
	assign deg       = dg_o;
	assign sat       = sat_o;

endmodule

// ===== hdl/triangle_barycentric_interpolate.sv =====
// Barycentric interpolation of a value over a triangle.
//
// A transaction carries a query point and three vertices (x, y and a value z
// each). It is accepted at a rising edge where start is high and busy is low.
// The interpolated value then appears on interp_z together with
// the degenerate and saturated flags, for exactly one cycle, marked by done.
// The receiver cannot stall; done is a strobe and the result is gone after it.
//
// The result passes through seven geometry stages, the queue, a sign stage,
// an overflow check, one restoring division stage per result bit and the
// saturation register. Throughput is one transaction per cycle while busy is
// low; the divider has a stage of its own for every bit.
//
// busy rises only when the queue between the geometry front end and the
// divider could not take every transaction still in flight. Since the
// divider drains one entry a cycle, that never happens in practice.
// Reset clears all valid bits and the queue; no result is pending after it.
module triangle_barycentric_interpolate #(
	parameter int COORD_BITS = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] query_x,
	input  logic signed [COORD_BITS-1:0] query_y,
	input  logic signed [COORD_BITS-1:0] vertex1_x,
	input  logic signed [COORD_BITS-1:0] vertex1_y,
	input  logic signed [VALUE_BITS-1:0] vertex1_z,
	input  logic signed [COORD_BITS-1:0] vertex2_x,
	input  logic signed [COORD_BITS-1:0] vertex2_y,
	input  logic signed [VALUE_BITS-1:0] vertex2_z,
	input  logic signed [COORD_BITS-1:0] vertex3_x,
	input  logic signed [COORD_BITS-1:0] vertex3_y,
	input  logic signed [VALUE_BITS-1:0] vertex3_z,
	output logic                         done,
	output logic signed [VALUE_BITS-1:0] interp_z,
	output logic                         degenerate,
	output logic                         saturated
);

	// Twice the area and each weight numerator fit in AW bits; the weighted
	// sum of values fits in NW bits.
	localparam int AW = 2 * COORD_BITS + 3;
	localparam int NW = AW + VALUE_BITS + 2;

	logic                 accept;
	logic                 f_valid;
	logic signed [NW-1:0] f_num;
	logic signed [AW-1:0] f_area;
	logic                 q_valid;
	logic [NW+AW-1:0]     q_data;
	tbi_pkg::qcnt_t       q_count;

	assign accept = start && !busy;

	// Hold off new transactions while the queue lacks room for everything
	// that the front end could still deliver.
	assign busy = (q_count > tbi_pkg::qcnt_t'(tbi_pkg::QDEPTH - tbi_pkg::QROOM));

	tbi_front #(
		.CB(COORD_BITS),
		.VB(VALUE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.qx       (query_x),
		.qy       (query_y),
		.x1       (vertex1_x),
		.y1       (vertex1_y),
		.z1       (vertex1_z),
		.x2       (vertex2_x),
		.y2       (vertex2_y),
		.z2       (vertex2_z),
		.x3       (vertex3_x),
		.y3       (vertex3_y),
		.z3       (vertex3_z),
		.out_valid(f_valid),
		.num      (f_num),
		.area     (f_area)
	);

	// The queue carries the numerator and twice the area as one word.
	tbi_queue #(
		.W(NW + AW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_valid),
		.wdata    ({f_num, f_area}),
		.out_valid(q_valid),
		.rdata    (q_data),
		.count    (q_count)
	);

	tbi_div #(
		.CB(COORD_BITS),
		.VB(VALUE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_valid),
		.num      ($signed(q_data[NW+AW-1:AW])),
		.area     ($signed(q_data[AW-1:0])),
		.out_valid(done),
		.res      (interp_z),
		.deg      (degenerate),
		.sat      (saturated)
	);

	// A degenerate triangle yields zero and never a saturation.
	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && degenerate |-> interp_z == '0 && !saturated)
		else $error("degenerate result not zero");

	// The queue must never be written while full.
	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		f_valid |-> q_count < tbi_pkg::qcnt_t'(tbi_pkg::QDEPTH))
		else $error("queue overflow");

	// The queue never holds more than its depth.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= tbi_pkg::qcnt_t'(tbi_pkg::QDEPTH))
		else $error("queue count out of range");

endmodule
